// ===== sv/lsb_stego_bmp_extractor_assert.svh =====
// Assertion macros for the LSB stego extractor RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef LSB_STEGO_BMP_EXTRACTOR_ASSERT_SVH
`define LSB_STEGO_BMP_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define LSBX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define LSBX_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lsbx_pkg.sv =====
// Types and constants of the LSB stego BMP extractor.
// No dependencies; imported by lsbx_front, lsbx_back and the top module.
package lsbx_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEADER_SKIP  = 2'd0;
    localparam logic [1:0] CFG_MAGIC_LENGTH = 2'd1;
    localparam logic [1:0] CFG_MAGIC_TEXT   = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] HEADER_SKIP_RST  = 16'd54;
    localparam logic [3:0]  MAGIC_LENGTH_RST = 4'd2;
    localparam logic [63:0] MAGIC_TEXT_RST   = 64'h0000_0000_0000_2A23;

    // Result status codes
    typedef enum logic [2:0] {
        CODE_EXT      = 3'd0,
        CODE_PAY      = 3'd1,
        CODE_MISMATCH = 3'd2,
        CODE_EXT_LONG = 3'd3,
        CODE_TRUNC    = 3'd4,
        CODE_EMPTY    = 3'd5
    } t_code;

    // One input item
    typedef struct packed {
        logic [7:0] image_byte;
        logic       start_of_image;
        logic       end_of_image;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        t_code      out_code;
        logic       last;
    } t_out_item;

    // Classified item passed from front to back
    typedef struct packed {
        logic data_bit;
        logic is_data;
        logic sof;
        logic eof;
    } t_mid_item;

    // Configuration register set
    typedef struct packed {
        logic [15:0] header_skip;
        logic [3:0]  magic_length;
        logic [63:0] magic_text;
    } t_cfg;

endpackage

// ===== sv/lsbx_fifo.sv =====
// Small first-in first-out queue of packed words.
// No dependencies; used between front and back and on the result side.
module lsbx_fifo #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(D - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(D);

    logic [W-1:0]  r_mem [D];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== sv/lsbx_front.sv =====
// Front end: accepts image bytes, counts off the header, classifies items.
// Depends on lsbx_pkg; feeds the mid queue read by lsbx_back.
module lsbx_front
    import lsbx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_push,
    input  t_in_item  i_item,
    output logic      o_full,
    input  logic      i_mid_full,
    output logic      o_mid_push,
    output t_mid_item o_mid_item
);

    logic [15:0] r_hdr_cnt;
    logic        r_hdr_done;
    logic [15:0] n_hdr_cnt;
    logic        n_hdr_done;
    logic [15:0] cnt_e;
    logic        done_e;
    logic        is_hdr;
    logic        accept;

    assign o_full = i_mid_full;
    assign accept = i_push && !i_mid_full;

    // Header classification; a start flag restarts the count first
    always_comb begin
        cnt_e      = i_item.start_of_image ? '0 : r_hdr_cnt;
        done_e     = i_item.start_of_image ? 1'b0 : r_hdr_done;
        is_hdr     = !done_e && (cnt_e < i_cfg.header_skip);
        n_hdr_cnt  = is_hdr ? cnt_e + 16'd1 : cnt_e;
        n_hdr_done = done_e || !is_hdr;
    end

    // Pure header bytes without flags carry nothing for the back end
    assign o_mid_push = accept &&
                        (!is_hdr || i_item.start_of_image || i_item.end_of_image);
    assign o_mid_item = '{data_bit: i_item.image_byte[0],
                          is_data:  !is_hdr,
                          sof:      i_item.start_of_image,
                          eof:      i_item.end_of_image};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt  <= '0;
            r_hdr_done <= 1'b0;
        end else if (accept) begin
            r_hdr_cnt  <= n_hdr_cnt;
            r_hdr_done <= n_hdr_done;
        end
    end

endmodule

// ===== sv/lsbx_back.sv =====
// Back end: bit gatherer and record decoder, one item per cycle while the result queue has room.
// Depends on lsbx_pkg and the assertion macro header.
`include "lsb_stego_bmp_extractor_assert.svh"

module lsbx_back
    import lsbx_pkg::*;
#(
    parameter int MAX_EXTENSION = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_mid_empty,
    input  t_mid_item i_mid_item,
    output logic      o_mid_pop,
    input  logic      i_res_space,
    output logic      o_res_push,
    output t_out_item o_res
);

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_EXT_LEN,
        PH_EXT,
        PH_PAY_LEN,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    localparam logic [31:0] EXT_MAX = 32'(MAX_EXTENSION);

    t_phase      r_phase, n_phase, ph_e;
    logic [4:0]  r_bit_cnt, n_bit_cnt, bc_e;
    logic [31:0] r_shift, n_shift, sh_e;
    logic [2:0]  r_mag_idx, n_mag_idx, idx_e;
    logic [31:0] r_remain, n_remain, rem_e;
    logic        r_bad, n_bad, bad_e;

    logic        take;
    logic [31:0] value;
    logic        need32;
    logic        complete;
    logic [2:0]  mag_last;
    logic [7:0]  mag_byte;
    logic        bad_now;
    logic        res_valid;
    t_out_item   res;

    assign take      = !i_mid_empty && i_res_space;
    assign o_mid_pop = take;

    // Last magic index: zero length counts as one, above eight as eight
    always_comb begin
        if (i_cfg.magic_length == 4'd0) begin
            mag_last = 3'd0;
        end else if (i_cfg.magic_length > 4'd8) begin
            mag_last = 3'd7;
        end else begin
            mag_last = 3'(i_cfg.magic_length - 4'd1);
        end
    end

    assign mag_byte = i_cfg.magic_text[{idx_e, 3'b000} +: 8];

    // Decoder next state
    always_comb begin
        ph_e  = r_phase;
        bc_e  = r_bit_cnt;
        sh_e  = r_shift;
        idx_e = r_mag_idx;
        rem_e = r_remain;
        bad_e = r_bad;
        if (i_mid_item.sof) begin
            ph_e  = PH_MAGIC;
            bc_e  = '0;
            sh_e  = '0;
            idx_e = '0;
            rem_e = '0;
            bad_e = 1'b0;
        end

        n_phase   = ph_e;
        n_bit_cnt = bc_e;
        n_shift   = sh_e;
        n_mag_idx = idx_e;
        n_remain  = rem_e;
        n_bad     = bad_e;
        res_valid = 1'b0;
        res       = '{out_byte: 8'd0, out_code: CODE_EXT, last: 1'b0};

        value    = sh_e | (32'(i_mid_item.data_bit) << bc_e);
        need32   = (ph_e == PH_EXT_LEN) || (ph_e == PH_PAY_LEN);
        complete = need32 ? (bc_e == 5'd31) : (bc_e == 5'd7);
        bad_now  = bad_e || (value[7:0] != mag_byte);

        if (ph_e != PH_DONE) begin
            if (i_mid_item.is_data) begin
                if (!complete) begin
                    n_bit_cnt = bc_e + 5'd1;
                    n_shift   = value;
                end else begin
                    n_bit_cnt = '0;
                    n_shift   = '0;
                    unique case (ph_e)
                        PH_MAGIC: begin
                            n_bad = bad_now;
                            if (idx_e == mag_last) begin
                                n_mag_idx = '0;
                                if (bad_now) begin
                                    res_valid = 1'b1;
                                    res = '{out_byte: 8'd0, out_code: CODE_MISMATCH,
                                            last: 1'b1};
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase = PH_EXT_LEN;
                                end
                            end else begin
                                n_mag_idx = idx_e + 3'd1;
                            end
                        end
                        PH_EXT_LEN: begin
                            n_remain = value;
                            if (value > EXT_MAX) begin
                                res_valid = 1'b1;
                                res = '{out_byte: 8'd0, out_code: CODE_EXT_LONG,
                                        last: 1'b1};
                                n_phase = PH_DONE;
                            end else if (value == '0) begin
                                n_phase = PH_PAY_LEN;
                            end else begin
                                n_phase = PH_EXT;
                            end
                        end
                        PH_EXT: begin
                            res_valid = 1'b1;
                            res = '{out_byte: value[7:0], out_code: CODE_EXT, last: 1'b0};
                            n_remain = rem_e - 32'd1;
                            if (rem_e <= 32'd1) begin
                                n_phase = PH_PAY_LEN;
                            end
                        end
                        PH_PAY_LEN: begin
                            n_remain = value;
                            if (value == '0) begin
                                res_valid = 1'b1;
                                res = '{out_byte: 8'd0, out_code: CODE_EMPTY, last: 1'b1};
                                n_phase = PH_DONE;
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end
                        PH_PAYLOAD: begin
                            res_valid = 1'b1;
                            res = '{out_byte: value[7:0], out_code: CODE_PAY,
                                    last: (rem_e <= 32'd1)};
                            n_remain = rem_e - 32'd1;
                            if (rem_e <= 32'd1) begin
                                n_phase = PH_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // End of image before completion overrides any character
            if (i_mid_item.eof && (n_phase != PH_DONE)) begin
                res_valid = 1'b1;
                res       = '{out_byte: 8'd0, out_code: CODE_TRUNC, last: 1'b1};
                n_phase   = PH_DONE;
            end
        end
    end

    assign o_res_push = take && res_valid;
    assign o_res      = res;

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MAGIC;
            r_bit_cnt <= '0;
            r_shift   <= '0;
            r_mag_idx <= '0;
            r_remain  <= '0;
            r_bad     <= 1'b0;
        end else if (take) begin
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            r_mag_idx <= n_mag_idx;
            r_remain  <= n_remain;
            r_bad     <= n_bad;
        end
    end

    // A terminal result leaves the decoder finished
    `LSBX_ASSERT_NXT(a_last_ends, i_clk, i_rst_n, o_res_push && o_res.last, r_phase == PH_DONE, "terminal result did not end decoding")
    // Once finished, only a start flag brings results again
    `LSBX_ASSERT_IMP(a_done_quiet, i_clk, i_rst_n, take && (r_phase == PH_DONE) && !i_mid_item.sof, !o_res_push, "result while finished")
    // Character phases never gather more than eight bits
    `LSBX_ASSERT_IMP(a_char_bits, i_clk, i_rst_n, (r_phase == PH_MAGIC) || (r_phase == PH_EXT) || (r_phase == PH_PAYLOAD), r_bit_cnt < 5'd8, "bit count overran a character")
    // Results are only pushed into a queue with room
    `LSBX_ASSERT_IMP(a_res_room, i_clk, i_rst_n, o_res_push, i_res_space && !i_mid_empty, "result pushed without room")

endmodule

// ===== sv/lsb_stego_bmp_extractor.sv =====
// Top level of the LSB stego BMP extractor: config registers, front, queues, back.
// Depends on lsbx_pkg, lsbx_fifo, lsbx_front and lsbx_back.
//
// Feed image bytes one per transfer on push/full; decoded extension and
// payload characters and terminal status codes come out on empty/pop.
// The block sustains one byte per clock: the front counts off the header
// and forwards data bits into a MID_DEPTH queue, and the back end's decoder
// folds one bit per cycle into its shift register, so it keeps pace as long
// as the OUT_DEPTH result queue has room.
// With both queues empty, a byte's item is registered in the mid queue and its
// result in the result queue before the result appears on the result side.
// Configuration writes are always ready and take effect at once; write them
// only while no transfer is in flight.
module lsb_stego_bmp_extractor
    import lsbx_pkg::*;
#(
    parameter int MAX_EXTENSION = 16,
    parameter int MID_DEPTH     = 4,
    parameter int OUT_DEPTH     = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // image byte channel
    input  logic        push,
    input  t_in_item    i_item,
    output logic        full,
    // result channel
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_result,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      mid_full;
    logic      mid_push;
    t_mid_item mid_in;
    logic      mid_empty;
    logic      mid_pop;
    t_mid_item mid_out;
    logic      res_full;
    logic      res_push;
    t_out_item res_in;
    logic      res_space;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_skip  <= HEADER_SKIP_RST;
            r_cfg.magic_length <= MAGIC_LENGTH_RST;
            r_cfg.magic_text   <= MAGIC_TEXT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEADER_SKIP:  r_cfg.header_skip  <= i_cfg_data[15:0];
                CFG_MAGIC_LENGTH: r_cfg.magic_length <= i_cfg_data[3:0];
                CFG_MAGIC_TEXT:   r_cfg.magic_text   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lsbx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .i_mid_full (mid_full),
        .o_mid_push (mid_push),
        .o_mid_item (mid_in)
    );

    lsbx_fifo #(
        .W ($bits(t_mid_item)),
        .D (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_out),
        .o_empty (mid_empty)
    );

    // The back end only advances while the result queue has room
    assign res_space = !res_full;

    lsbx_back #(
        .MAX_EXTENSION (MAX_EXTENSION)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_mid_empty (mid_empty),
        .i_mid_item  (mid_out),
        .o_mid_pop   (mid_pop),
        .i_res_space (res_space),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // Result queue feeding the result port
    lsbx_fifo #(
        .W ($bits(t_out_item)),
        .D (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for lsb_stego_bmp_extractor: directed rows, then random stego images.
// Depends on lsbx_pkg and the extractor RTL; an internal decoder model or a row's fixed value predicts each result.
module tb_top;
    import lsbx_pkg::*;

    localparam int          MAX_EXT     = 16;
    localparam int          ITEM_GOAL   = 1900;
    localparam int          RAND_GOAL   = ITEM_GOAL - 500;
    localparam int          LONG_SKIP   = 256;
    localparam int          SETTLE      = 16;
    localparam int          END_WAIT    = 5000;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          IMG_KINDS   = 7;
    localparam logic [1:0]  CFG_UNUSED  = 2'd3;

    // Decoder phases of the model
    typedef enum logic [2:0] {
        DEC_HEADER, DEC_MAGIC, DEC_EXT_LEN, DEC_EXT, DEC_PAY_LEN, DEC_PAYLOAD, DEC_DONE
    } dec_phase_e;

    // Shapes of generated images
    typedef enum int {
        IMG_GOOD, IMG_BAD_MAGIC, IMG_EXT_LONG, IMG_EMPTY, IMG_TRUNC, IMG_RESTART, IMG_NOISE
    } img_kind_e;

    typedef enum int { ROW_BYTE, ROW_WRITE } row_kind_e;
    typedef enum int { CHK_MODEL, CHK_NONE, CHK_VALUE } chk_mode_e;

    typedef struct {
        row_kind_e   kind;
        logic [1:0]  cfg_idx;
        logic [63:0] cfg_val;
        t_in_item    item;
        chk_mode_e   chk;
        t_out_item   want;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    t_in_item    i_item      = '0;
    logic        full;
    logic        empty;
    logic        pop         = 1'b0;
    t_out_item   o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data  = '0;

    // Model copy of the registers and decoder state
    logic [15:0] cfg_skip  = HEADER_SKIP_RST;
    logic [3:0]  cfg_mlen  = MAGIC_LENGTH_RST;
    logic [63:0] cfg_mtext = MAGIC_TEXT_RST;
    dec_phase_e  dec_ph;
    logic [15:0] hdr_cnt;
    logic [5:0]  bit_cnt;
    logic [31:0] shift_reg;
    logic [31:0] item_cnt;
    logic [31:0] ext_len;
    logic [31:0] pay_len;
    logic        magic_bad;

    t_out_item   decoded_q[$];
    t_in_item    img_q[$];
    stim_row_t   dir_rows[$];

    bit          feed_calm = 1'b0;
    bit          pop_calm  = 1'b0;
    int unsigned cyc = 0;
    int unsigned live_items = 0;
    int unsigned sent_cnt = 0;
    int unsigned checked_cnt = 0;
    int unsigned write_cnt = 0;
    int unsigned images_run[IMG_KINDS];
    int          err_cnt = 0;

    lsb_stego_bmp_extractor #(
        .MAX_EXTENSION(MAX_EXT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited", cyc, decoded_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        if (err_cnt < 40)
            $display("ERROR cycle %0d: %s", cyc, msg);
        err_cnt++;
    endtask

    function automatic int unsigned magic_chars();
        if (cfg_mlen == 4'd0) return 1;
        if (cfg_mlen > 4'd8) return 8;
        return int'(cfg_mlen);
    endfunction

    function automatic void clear_decoder();
        dec_ph    = DEC_HEADER;
        hdr_cnt   = '0;
        bit_cnt   = '0;
        shift_reg = '0;
        item_cnt  = '0;
        ext_len   = '0;
        pay_len   = '0;
        magic_bad = 1'b0;
    endfunction

    function automatic void set_reg(input logic [1:0] idx, input logic [63:0] val);
        case (idx)
            CFG_HEADER_SKIP:  cfg_skip  = val[15:0];
            CFG_MAGIC_LENGTH: cfg_mlen  = val[3:0];
            CFG_MAGIC_TEXT:   cfg_mtext = val;
            default: ;
        endcase
    endfunction

    function automatic t_out_item status(input t_code code);
        t_out_item r;
        r.out_byte = 8'h00;
        r.out_code = code;
        r.last     = 1'b1;
        return r;
    endfunction

    // Decoder model: one image byte in, at most one character or status out
    function automatic bit decode_byte(input t_in_item it, output t_out_item res);
        bit          has;
        int unsigned need;
        logic [31:0] word;
        has = 1'b0;
        res = '0;
        if (it.start_of_image) clear_decoder();
        if (dec_ph == DEC_DONE) return 1'b0;
        live_items++;
        if (dec_ph == DEC_HEADER && hdr_cnt < cfg_skip) begin
            hdr_cnt = hdr_cnt + 16'd1;
        end else begin
            if (dec_ph == DEC_HEADER) dec_ph = DEC_MAGIC;
            shift_reg = shift_reg | (32'(it.image_byte[0]) << bit_cnt[4:0]);
            bit_cnt   = bit_cnt + 6'd1;
            need = (dec_ph == DEC_EXT_LEN || dec_ph == DEC_PAY_LEN) ? 32 : 8;
            if (bit_cnt >= need) begin
                word      = shift_reg;
                shift_reg = '0;
                bit_cnt   = '0;
                case (dec_ph)
                    DEC_MAGIC: begin
                        if (word[7:0] != cfg_mtext[{item_cnt[2:0], 3'b000} +: 8])
                            magic_bad = 1'b1;
                        item_cnt = item_cnt + 1;
                        if (item_cnt >= magic_chars()) begin
                            item_cnt = '0;
                            if (magic_bad) begin
                                res = status(CODE_MISMATCH);
                                has = 1'b1;
                                dec_ph = DEC_DONE;
                            end else begin
                                dec_ph = DEC_EXT_LEN;
                            end
                        end
                    end
                    DEC_EXT_LEN: begin
                        ext_len  = word;
                        item_cnt = '0;
                        if (word > 32'(MAX_EXT)) begin
                            res = status(CODE_EXT_LONG);
                            has = 1'b1;
                            dec_ph = DEC_DONE;
                        end else begin
                            dec_ph = (word == 0) ? DEC_PAY_LEN : DEC_EXT;
                        end
                    end
                    DEC_EXT: begin
                        res.out_byte = word[7:0];
                        res.out_code = CODE_EXT;
                        res.last     = 1'b0;
                        has = 1'b1;
                        item_cnt = item_cnt + 1;
                        if (item_cnt >= ext_len) begin
                            item_cnt = '0;
                            dec_ph = DEC_PAY_LEN;
                        end
                    end
                    DEC_PAY_LEN: begin
                        pay_len  = word;
                        item_cnt = '0;
                        if (word == 0) begin
                            res = status(CODE_EMPTY);
                            has = 1'b1;
                            dec_ph = DEC_DONE;
                        end else begin
                            dec_ph = DEC_PAYLOAD;
                        end
                    end
                    default: begin
                        item_cnt = item_cnt + 1;
                        res.out_byte = word[7:0];
                        res.out_code = CODE_PAY;
                        res.last     = (item_cnt >= pay_len);
                        if (item_cnt >= pay_len) dec_ph = DEC_DONE;
                        has = 1'b1;
                    end
                endcase
            end
        end
        // end of image before the record is complete
        if (it.end_of_image && dec_ph != DEC_DONE) begin
            res = status(CODE_TRUNC);
            has = 1'b1;
            dec_ph = DEC_DONE;
        end
        return has;
    endfunction

    // Wait for all awaited results, then let the pipeline empty
    task automatic quiesce(input int max_cycles);
        int k;
        push <= 1'b0;
        k = 0;
        while (decoded_q.size() != 0 && k < max_cycles) begin
            @(posedge i_clk);
            k++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        quiesce(CYCLE_LIMIT);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        set_reg(idx, val);
        write_cnt++;
    endtask

    // One byte transfer; the model advances on acceptance
    task automatic send_item(input t_in_item it, input chk_mode_e chk, input t_out_item want);
        int        gap;
        t_out_item r;
        bit        has;
        gap = feed_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sent_cnt++;
        has = decode_byte(it, r);
        case (chk)
            CHK_MODEL: if (has) decoded_q.push_back(r);
            CHK_VALUE: decoded_q.push_back(want);
            default: ;
        endcase
    endtask

    // Result side: random stalls, compare against the oldest awaited result
    initial begin : popper
        int        stall;
        t_out_item got;
        t_out_item w;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = pop_calm ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got = o_result;
            checked_cnt++;
            if (decoded_q.size() == 0) begin
                flag_error($sformatf("unawaited result: byte %02h code %0d last %0b",
                                     got.out_byte, got.out_code, got.last));
            end else begin
                w = decoded_q.pop_front();
                if (got.out_byte !== w.out_byte)
                    flag_error($sformatf("out_byte %02h, want %02h", got.out_byte, w.out_byte));
                if (got.out_code !== w.out_code)
                    flag_error($sformatf("out_code %0d, want %0d", got.out_code, w.out_code));
                if (got.last !== w.last)
                    flag_error($sformatf("last %0b, want %0b", got.last, w.last));
            end
            if ($urandom_range(0, 19) == 0) pop_calm = !pop_calm;
        end
    end

    function automatic void add_bits(input logic [31:0] v, input int n);
        t_in_item x;
        for (int i = 0; i < n; i++) begin
            x.image_byte     = {7'($urandom), v[i]};
            x.start_of_image = 1'b0;
            x.end_of_image   = 1'b0;
            img_q.push_back(x);
        end
    endfunction

    // Build one image byte stream of the given shape for the current settings
    function automatic void build_image(input img_kind_e kind);
        int unsigned mc;
        int          bad_i;
        int          ext_n;
        int          pay_n;
        int          cut;
        logic [7:0]  ch;
        logic [31:0] elen;
        logic [31:0] plen;
        t_in_item    x;
        img_q.delete();
        if (kind == IMG_NOISE) begin
            repeat ($urandom_range(4, 40)) begin
                x.image_byte     = 8'($urandom);
                x.start_of_image = ($urandom_range(0, 7) == 0);
                x.end_of_image   = ($urandom_range(0, 7) == 0);
                img_q.push_back(x);
            end
            return;
        end
        for (int i = 0; i < int'(cfg_skip); i++) begin
            x.image_byte     = 8'($urandom);
            x.start_of_image = 1'b0;
            x.end_of_image   = 1'b0;
            img_q.push_back(x);
        end
        // magic characters, one bit flipped for a mismatch
        mc    = magic_chars();
        bad_i = $urandom_range(0, mc - 1);
        for (int i = 0; i < int'(mc); i++) begin
            ch = cfg_mtext[i*8 +: 8];
            if (kind == IMG_BAD_MAGIC && i == bad_i) ch = ch ^ (8'h01 << $urandom_range(0, 7));
            add_bits(32'(ch), 8);
        end
        // extension length and characters
        ext_n = ($urandom_range(0, 7) == 0) ? MAX_EXT : $urandom_range(0, 4);
        elen  = 32'(ext_n);
        if (kind == IMG_EXT_LONG)
            elen = $urandom_range(0, 1) ? 32'($urandom_range(MAX_EXT + 1, 64))
                                        : ($urandom | 32'h20);
        add_bits(elen, 32);
        if (kind != IMG_EXT_LONG)
            repeat (ext_n) add_bits($urandom, 8);
        // payload length and characters
        plen = 32'($urandom_range(1, 8));
        if (kind == IMG_EMPTY) plen = '0;
        if (kind == IMG_TRUNC && $urandom_range(0, 1)) plen = $urandom | 32'h100;
        add_bits(plen, 32);
        pay_n = (plen <= 8) ? int'(plen) : $urandom_range(0, 6);
        repeat (pay_n) add_bits($urandom, 8);
        if (kind == IMG_TRUNC || kind == IMG_RESTART) begin
            cut = $urandom_range(0, img_q.size() - 1);
            while (img_q.size() > cut + 1) void'(img_q.pop_back());
        end else begin
            // bytes after the record are ignored
            repeat ($urandom_range(0, 3)) add_bits($urandom, 1);
        end
        if (kind != IMG_RESTART) img_q[img_q.size() - 1].end_of_image = 1'b1;
        img_q[0].start_of_image = 1'b1;
    endfunction

    task automatic run_image(input img_kind_e kind, input bit hurry);
        build_image(kind);
        feed_calm = hurry || ($urandom_range(0, 3) == 0);
        foreach (img_q[k]) begin
            if (!hurry && $urandom_range(0, 249) == 0) quiesce(CYCLE_LIMIT);
            send_item(img_q[k], CHK_MODEL, '0);
        end
        images_run[kind]++;
    endtask

    task automatic pick_config(input int rnd);
        logic [15:0] skip;
        logic [3:0]  mlen;
        logic [63:0] text;
        case (rnd)
            0: begin skip = 16'd0; mlen = 4'd1; text = {$urandom, $urandom}; end
            1: begin skip = 16'd1; mlen = 4'd8; text = '1; end
            2: begin skip = 16'd3; mlen = 4'd15; text = '0; end
            3: begin skip = HEADER_SKIP_RST; mlen = MAGIC_LENGTH_RST; text = MAGIC_TEXT_RST; end
            default: begin
                skip = 16'($urandom_range(0, 12));
                mlen = 4'($urandom_range(0, 15));
                text = {$urandom, $urandom};
            end
        endcase
        write_reg(CFG_HEADER_SKIP, 64'(skip));
        write_reg(CFG_MAGIC_LENGTH, 64'(mlen));
        write_reg(CFG_MAGIC_TEXT, text);
    endtask

    function automatic void byte_row(input logic [7:0] b, input logic sof, input logic eof,
                                     input chk_mode_e chk, input t_out_item want);
        stim_row_t r;
        r.kind    = ROW_BYTE;
        r.cfg_idx = '0;
        r.cfg_val = '0;
        r.item    = '{image_byte: b, start_of_image: sof, end_of_image: eof};
        r.chk     = chk;
        r.want    = want;
        dir_rows.push_back(r);
    endfunction

    function automatic void write_row(input logic [1:0] idx, input logic [63:0] val);
        stim_row_t r;
        r.kind    = ROW_WRITE;
        r.cfg_idx = idx;
        r.cfg_val = val;
        r.item    = '0;
        r.chk     = CHK_NONE;
        r.want    = '0;
        dir_rows.push_back(r);
    endfunction

    // Directed rows: reset settings, ignored bytes, restarts, unused index write, magic check, truncation
    function automatic void fill_rows();
        byte_row(8'hFF, 1'b1, 1'b1, CHK_VALUE, status(CODE_TRUNC));
        byte_row(8'h00, 1'b0, 1'b1, CHK_NONE,  '0);
        byte_row(8'h01, 1'b0, 1'b0, CHK_NONE,  '0);
        byte_row(8'hA5, 1'b1, 1'b0, CHK_NONE,  '0);
        byte_row(8'h5A, 1'b0, 1'b1, CHK_VALUE, status(CODE_TRUNC));
        write_row(CFG_UNUSED, '1);
        write_row(CFG_HEADER_SKIP, 64'd0);
        write_row(CFG_MAGIC_LENGTH, 64'd0);
        write_row(CFG_MAGIC_TEXT, 64'hFFFF_FFFF_FFFF_FF41);
        // one magic char 0x40 against 0x41
        byte_row(8'hFE, 1'b1, 1'b0, CHK_MODEL, '0);
        byte_row(8'h00, 1'b0, 1'b0, CHK_MODEL, '0);
        byte_row(8'h80, 1'b0, 1'b0, CHK_MODEL, '0);
        byte_row(8'h7E, 1'b0, 1'b0, CHK_MODEL, '0);
        byte_row(8'hFE, 1'b0, 1'b0, CHK_MODEL, '0);
        byte_row(8'h02, 1'b0, 1'b0, CHK_MODEL, '0);
        byte_row(8'hFF, 1'b0, 1'b0, CHK_MODEL, '0);
        byte_row(8'h00, 1'b0, 1'b0, CHK_VALUE, status(CODE_MISMATCH));
        byte_row(8'h01, 1'b1, 1'b1, CHK_VALUE, status(CODE_TRUNC));
        // matching magic, then cut off in the extension length
        byte_row(8'h01, 1'b1, 1'b0, CHK_MODEL, '0);
        byte_row(8'hFE, 1'b0, 1'b0, CHK_MODEL, '0);
        byte_row(8'h00, 1'b0, 1'b0, CHK_MODEL, '0);
        byte_row(8'h80, 1'b0, 1'b0, CHK_MODEL, '0);
        byte_row(8'h7E, 1'b0, 1'b0, CHK_MODEL, '0);
        byte_row(8'h02, 1'b0, 1'b0, CHK_MODEL, '0);
        byte_row(8'hFF, 1'b0, 1'b0, CHK_MODEL, '0);
        byte_row(8'h40, 1'b0, 1'b0, CHK_MODEL, '0);
        byte_row(8'hFF, 1'b0, 1'b1, CHK_VALUE, status(CODE_TRUNC));
    endfunction

    // Main sequence
    initial begin : stimulus
        int        rnd;
        img_kind_e kind;
        clear_decoder();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        fill_rows();
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE)
                write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
            else
                send_item(dir_rows[i].item, dir_rows[i].chk, dir_rows[i].want);
        end

        // Random images, every shape once first
        rnd = 0;
        while (sent_cnt < RAND_GOAL || rnd < 2) begin
            pick_config(rnd);
            for (int n = 0; n < 4; n++) begin
                if (rnd * 4 + n >= IMG_KINDS && sent_cnt >= RAND_GOAL) break;
                if (rnd * 4 + n < IMG_KINDS)
                    kind = img_kind_e'(rnd * 4 + n);
                else if ($urandom_range(0, 1))
                    kind = IMG_GOOD;
                else
                    kind = img_kind_e'($urandom_range(0, IMG_KINDS - 1));
                run_image(kind, 1'b0);
            end
            rnd++;
        end

        // A long header once, streamed without gaps
        write_reg(CFG_HEADER_SKIP, 64'(LONG_SKIP));
        run_image(IMG_GOOD, 1'b1);

        quiesce(END_WAIT);
        if (decoded_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", decoded_q.size()));
        $display("%0d image bytes sent (%0d decoded), %0d results checked, %0d writes, %0d errors",
                 sent_cnt, live_items, checked_cnt, write_cnt, err_cnt);
        $display("images: %0d complete, %0d bad magic, %0d long ext, %0d empty,",
                 images_run[IMG_GOOD], images_run[IMG_BAD_MAGIC], images_run[IMG_EXT_LONG],
                 images_run[IMG_EMPTY]);
        $display("        %0d cut, %0d restarted, %0d noise",
                 images_run[IMG_TRUNC], images_run[IMG_RESTART], images_run[IMG_NOISE]);
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/lsbx_pkg.sv
sv/lsbx_fifo.sv
sv/lsbx_front.sv
sv/lsbx_back.sv
sv/lsb_stego_bmp_extractor.sv
tb/sv/tb_top.sv
